@@ rtl/sstp_pkg.sv @@
// Shared types and constants for the spectral type parser.
// This file has no dependencies. Every other file in rtl/ refers to it by scoped names.
package sstp_pkg;

  // Parser states. The numbering is fixed, and some codes are never used.
  typedef enum logic [4:0] {
    PS_BEGIN     = 5'd0,
    PS_END       = 5'd1,
    PS_WR_TYPE   = 5'd3,
    PS_CLASS     = 5'd4,
    PS_SUB       = 5'd5,
    PS_SUB_DEC   = 5'd6,
    PS_SUB_FIN   = 5'd7,
    PS_LUM_BEGIN = 5'd8,
    PS_LUM_I     = 5'd9,
    PS_LUM_II    = 5'd10,
    PS_LUM_V     = 5'd11,
    PS_LUM_IDASH = 5'd12,
    PS_LUM_IA    = 5'd13,
    PS_WD_TYPE   = 5'd14,
    PS_WD_EXT    = 5'd15,
    PS_WD_SUB    = 5'd16,
    PS_SUBDWARF  = 5'd17
  } parse_state_t;

  // Star type codes.
  typedef enum logic [1:0] {
    STAR_NORMAL  = 2'd0,
    STAR_WD      = 2'd1,
    STAR_NEUTRON = 2'd2,
    STAR_BH      = 2'd3
  } star_type_t;

  // Spectral class codes.
  typedef enum logic [4:0] {
    CLS_O       = 5'd0,
    CLS_B       = 5'd1,
    CLS_A       = 5'd2,
    CLS_F       = 5'd3,
    CLS_G       = 5'd4,
    CLS_K       = 5'd5,
    CLS_M       = 5'd6,
    CLS_R       = 5'd7,
    CLS_S       = 5'd8,
    CLS_N       = 5'd9,
    CLS_WC      = 5'd10,
    CLS_WN      = 5'd11,
    CLS_L       = 5'd12,
    CLS_T       = 5'd13,
    CLS_C       = 5'd14,
    CLS_DA      = 5'd15,
    CLS_DB      = 5'd16,
    CLS_DC      = 5'd17,
    CLS_DO      = 5'd18,
    CLS_DQ      = 5'd19,
    CLS_DZ      = 5'd20,
    CLS_D       = 5'd21,
    CLS_UNKNOWN = 5'd22
  } spec_class_t;

  // Luminosity class codes.
  typedef enum logic [3:0] {
    LUM_IA0     = 4'd0,
    LUM_IA      = 4'd1,
    LUM_IB      = 4'd2,
    LUM_II      = 4'd3,
    LUM_III     = 4'd4,
    LUM_IV      = 4'd5,
    LUM_V       = 4'd6,
    LUM_VI      = 4'd7,
    LUM_NOT_SEEN = 4'd8
  } lum_class_t;

  // Subclass digit code used when no digit was found.
  localparam logic [3:0] SUB_UNKNOWN = 4'd10;

  // Characters that steer the parse.
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // Number of chained transitions evaluated for one character. This covers the
  // longest chain the state graph allows.
  localparam int ChainSteps = 4;

  // Full parse context, which is the state plus the accumulated fields.
  typedef struct packed {
    parse_state_t ps;
    star_type_t   star_type;
    spec_class_t  spec_class;
    logic [3:0]   subclass;
    lum_class_t   lum;
  } sstp_ctx_t;

  localparam sstp_ctx_t CtxReset = '{
    ps:         PS_BEGIN,
    star_type:  STAR_NORMAL,
    spec_class: CLS_UNKNOWN,
    subclass:   SUB_UNKNOWN,
    lum:        LUM_NOT_SEEN
  };

endpackage

@@ rtl/sstp_step.sv @@
// One transition of the spectral type parser state graph. This block is purely combinational.
// It depends on sstp_pkg.
module sstp_step (
  input  logic [7:0]          ch,
  input  sstp_pkg::sstp_ctx_t ctx_in,
  input  logic                active_in,
  output sstp_pkg::sstp_ctx_t ctx_out,
  output logic                active_out
);

  logic run;
  logic consumed;
  logic is_digit;
  logic is_term;
  logic is_wd_letter;

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_term  = (ch == sstp_pkg::CH_NUL);
  assign is_wd_letter = (ch == "A") || (ch == "B") || (ch == "C") ||
                        (ch == "O") || (ch == "Q") || (ch == "Z");
  assign run = active_in && (ctx_in.ps != sstp_pkg::PS_END);

  // Apply one transition. A non-terminator character stops the chain once it is
  // consumed. The terminator keeps the chain running until the end state.
  always_comb begin
    ctx_out  = ctx_in;
    consumed = 1'b0;
    if (run) begin
      case (ctx_in.ps)
        sstp_pkg::PS_BEGIN: begin
          if (ch == sstp_pkg::CH_Q) begin
            ctx_out.star_type = sstp_pkg::STAR_NEUTRON;
            ctx_out.ps = sstp_pkg::PS_END;
          end else if (ch == sstp_pkg::CH_X) begin
            ctx_out.star_type = sstp_pkg::STAR_BH;
            ctx_out.ps = sstp_pkg::PS_END;
          end else if (ch == sstp_pkg::CH_D) begin
            ctx_out.star_type  = sstp_pkg::STAR_WD;
            ctx_out.spec_class = sstp_pkg::CLS_D;
            ctx_out.ps = sstp_pkg::PS_WD_TYPE;
            consumed = 1'b1;
          end else if (ch == "s") begin
            ctx_out.ps = sstp_pkg::PS_SUBDWARF;
            consumed = 1'b1;
          end else if (ch == "?") begin
            ctx_out.ps = sstp_pkg::PS_END;
          end else begin
            ctx_out.ps = sstp_pkg::PS_CLASS;
          end
        end
        sstp_pkg::PS_WR_TYPE: begin
          ctx_out.ps = sstp_pkg::PS_SUB;
          if (ch == "N") begin
            ctx_out.spec_class = sstp_pkg::CLS_WN;
            consumed = 1'b1;
          end else begin
            ctx_out.spec_class = sstp_pkg::CLS_WC;
            consumed = (ch == "C");
          end
        end
        sstp_pkg::PS_SUBDWARF: begin
          if (ch == "d") begin
            ctx_out.lum = sstp_pkg::LUM_VI;
            ctx_out.ps = sstp_pkg::PS_CLASS;
            consumed = 1'b1;
          end else begin
            ctx_out.ps = sstp_pkg::PS_END;
          end
        end
        sstp_pkg::PS_CLASS: begin
          consumed = 1'b1;
          if (ch == sstp_pkg::CH_W) begin
            ctx_out.ps = sstp_pkg::PS_WR_TYPE;
          end else begin
            ctx_out.ps = sstp_pkg::PS_SUB;
            case (ch)
              "O": ctx_out.spec_class = sstp_pkg::CLS_O;
              "B": ctx_out.spec_class = sstp_pkg::CLS_B;
              "A": ctx_out.spec_class = sstp_pkg::CLS_A;
              "F": ctx_out.spec_class = sstp_pkg::CLS_F;
              "G": ctx_out.spec_class = sstp_pkg::CLS_G;
              "K": ctx_out.spec_class = sstp_pkg::CLS_K;
              "M": ctx_out.spec_class = sstp_pkg::CLS_M;
              "R": ctx_out.spec_class = sstp_pkg::CLS_R;
              "S": ctx_out.spec_class = sstp_pkg::CLS_S;
              "N": ctx_out.spec_class = sstp_pkg::CLS_N;
              "L": ctx_out.spec_class = sstp_pkg::CLS_L;
              "T": ctx_out.spec_class = sstp_pkg::CLS_T;
              "C": ctx_out.spec_class = sstp_pkg::CLS_C;
              default: ctx_out.ps = sstp_pkg::PS_END;
            endcase
          end
        end
        sstp_pkg::PS_SUB: begin
          if (is_digit) begin
            ctx_out.subclass = ch[3:0];
            ctx_out.ps = sstp_pkg::PS_SUB_DEC;
            consumed = 1'b1;
          end else begin
            ctx_out.ps = sstp_pkg::PS_LUM_BEGIN;
          end
        end
        sstp_pkg::PS_SUB_DEC: begin
          if (ch == sstp_pkg::CH_DOT) begin
            ctx_out.ps = sstp_pkg::PS_SUB_FIN;
            consumed = 1'b1;
          end else begin
            ctx_out.ps = sstp_pkg::PS_LUM_BEGIN;
          end
        end
        sstp_pkg::PS_SUB_FIN: begin
          consumed = 1'b1;
          if (is_digit) begin
            ctx_out.ps = sstp_pkg::PS_LUM_BEGIN;
          end else begin
            ctx_out.ps = sstp_pkg::PS_END;
          end
        end
        sstp_pkg::PS_LUM_BEGIN: begin
          consumed = 1'b1;
          if (ch == "I") begin
            ctx_out.ps = sstp_pkg::PS_LUM_I;
          end else if (ch == "V") begin
            ctx_out.ps = sstp_pkg::PS_LUM_V;
          end else begin
            ctx_out.ps = sstp_pkg::PS_END;
          end
        end
        sstp_pkg::PS_LUM_I: begin
          consumed = 1'b1;
          if (ch == "I") begin
            ctx_out.ps = sstp_pkg::PS_LUM_II;
          end else if (ch == "V") begin
            ctx_out.lum = sstp_pkg::LUM_IV;
            ctx_out.ps = sstp_pkg::PS_END;
          end else if (ch == "a") begin
            ctx_out.ps = sstp_pkg::PS_LUM_IA;
          end else if (ch == sstp_pkg::CH_DASH) begin
            ctx_out.ps = sstp_pkg::PS_LUM_IDASH;
          end else begin
            ctx_out.lum = sstp_pkg::LUM_IB;
            ctx_out.ps = sstp_pkg::PS_END;
          end
        end
        sstp_pkg::PS_LUM_II: begin
          ctx_out.ps = sstp_pkg::PS_END;
          if (ch == "I") begin
            ctx_out.lum = sstp_pkg::LUM_III;
          end else begin
            ctx_out.lum = sstp_pkg::LUM_II;
          end
        end
        sstp_pkg::PS_LUM_IDASH: begin
          // After "I-", the 'a' is read again by the Ia state.
          if (ch == "a") begin
            ctx_out.ps = sstp_pkg::PS_LUM_IA;
          end else begin
            ctx_out.lum = sstp_pkg::LUM_IB;
            ctx_out.ps = sstp_pkg::PS_END;
          end
        end
        sstp_pkg::PS_LUM_IA: begin
          ctx_out.ps = sstp_pkg::PS_END;
          if (ch == "0") begin
            ctx_out.lum = sstp_pkg::LUM_IA0;
          end else begin
            ctx_out.lum = sstp_pkg::LUM_IA;
          end
        end
        sstp_pkg::PS_LUM_V: begin
          ctx_out.ps = sstp_pkg::PS_END;
          if (ch == "I") begin
            ctx_out.lum = sstp_pkg::LUM_VI;
          end else begin
            ctx_out.lum = sstp_pkg::LUM_V;
          end
        end
        sstp_pkg::PS_WD_TYPE: begin
          ctx_out.ps = sstp_pkg::PS_WD_EXT;
          consumed = 1'b1;
          case (ch)
            "A": ctx_out.spec_class = sstp_pkg::CLS_DA;
            "B": ctx_out.spec_class = sstp_pkg::CLS_DB;
            "C": ctx_out.spec_class = sstp_pkg::CLS_DC;
            "O": ctx_out.spec_class = sstp_pkg::CLS_DO;
            "Q": ctx_out.spec_class = sstp_pkg::CLS_DQ;
            "Z": ctx_out.spec_class = sstp_pkg::CLS_DZ;
            default: begin
              ctx_out.spec_class = sstp_pkg::CLS_D;
              consumed = 1'b0;
            end
          endcase
        end
        sstp_pkg::PS_WD_EXT: begin
          // Extra white dwarf letters are skipped until something else shows up.
          if (is_wd_letter || (ch == "V") || (ch == "P") || (ch == "H") || (ch == "E")) begin
            consumed = 1'b1;
          end else begin
            ctx_out.ps = sstp_pkg::PS_WD_SUB;
          end
        end
        sstp_pkg::PS_WD_SUB: begin
          ctx_out.ps = sstp_pkg::PS_END;
          if (is_digit) begin
            ctx_out.subclass = ch[3:0];
            consumed = 1'b1;
          end
        end
        default: ctx_out.ps = sstp_pkg::PS_END;
      endcase
    end
  end

  // The chain continues only if this step ran and did not consume a normal character.
  assign active_out = run && (is_term || !consumed);

endmodule

@@ rtl/sstp_core.sv @@
// Parse context register together with the chain of transition steps that one character runs through.
// It depends on sstp_pkg and sstp_step.
module sstp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          ch,
  output sstp_pkg::sstp_ctx_t result
);

  sstp_pkg::sstp_ctx_t ctx;
  sstp_pkg::sstp_ctx_t ctx_chain [0:sstp_pkg::ChainSteps];
  logic                active_chain [0:sstp_pkg::ChainSteps];

  assign ctx_chain[0]    = ctx;
  assign active_chain[0] = 1'b1;

  // Chain of transitions for the current character.
  for (genvar i = 0; i < sstp_pkg::ChainSteps; i++) begin : g_step
    sstp_step u_step (
      .ch         (ch),
      .ctx_in     (ctx_chain[i]),
      .active_in  (active_chain[i]),
      .ctx_out    (ctx_chain[i+1]),
      .active_out (active_chain[i+1])
    );
  end

  assign result = ctx_chain[sstp_pkg::ChainSteps];

  // Context update. A terminator clears the context for the next string.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= sstp_pkg::CtxReset;
    end else if (fire) begin
      if (ch == sstp_pkg::CH_NUL) begin
        ctx <= sstp_pkg::CtxReset;
      end else begin
        ctx <= result;
      end
    end
  end

endmodule

@@ rtl/stellar_spectral_type_parser.sv @@
// Top level of the stellar spectral type parser. It holds the input register,
// the result register and the handshake logic. It depends on sstp_pkg and sstp_core.
//
// The block takes one character per clock cycle on the input channel. A zero byte ends a
// string and produces one result. That result is loaded into the output register when the
// terminator advances out of the input register, which it cannot do while the previous result
// is still waiting, and the parser is then clear for the next string. Up to four chained
// transitions per character are evaluated between the input register and the parse context
// register. The input side stalls only when a terminator waits in the input register and the
// previous result has not been taken.
module stellar_spectral_type_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] star_type,
  output logic [4:0] spectral_class,
  output logic [3:0] subclass_digit,
  output logic [3:0] lum_class
);

  logic                s1_valid;
  logic [7:0]          s1_ch;
  logic                s1_term;
  logic                s1_adv;
  logic                out_free;
  sstp_pkg::sstp_ctx_t result;

  // Stage advance control.
  assign s1_term  = (s1_ch == sstp_pkg::CH_NUL);
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!s1_term || out_free);
  assign in_ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch <= ch;
    end
  end

  sstp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_adv),
    .ch     (s1_ch),
    .result (result)
  );

  // Result register. It loads when a terminator advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_term) begin
      star_type      <= result.star_type;
      spectral_class <= result.spec_class;
      subclass_digit <= result.subclass;
      lum_class      <= result.lum;
    end
  end

  // A terminator that advances always yields a result in the next cycle.
  a_term_emits: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_term |=> out_valid)
    else $error("terminator advanced without a result");

  // The input side stalls only for a blocked terminator.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_term && out_valid && !out_ready)
    else $error("input stalled without a pending terminator");

  // Results carry only defined codes.
  a_codes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (spectral_class <= 5'd22) && (subclass_digit <= 4'd10) &&
                  (lum_class <= 4'd8))
    else $error("result code out of range");

endmodule

@@ verif/spectral_reading_checker.sv @@
// Checker for the spectral type parser: watches both channels, predicts each reading
// from the accepted characters and compares it with what the block delivers.
// Depends on sstp_pkg for the state, class and character codes.
module spectral_reading_checker
  import sstp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] ch,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] star_type,
  input  logic [4:0] spectral_class,
  input  logic [3:0] subclass_digit,
  input  logic [3:0] lum_class,
  output int         misses,
  output int         open_readings
);

  // Longest run of transitions allowed on one character.
  localparam int ChainCap = 16;

  typedef struct packed {
    star_type_t  kind;
    spec_class_t cls;
    logic [3:0]  sub;
    lum_class_t  lum;
  } reading_t;

  sstp_ctx_t scan;
  reading_t  expected_readings[$];

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // One move of the parse; returns 1 when the character is used up.
  function automatic bit advance(inout sstp_ctx_t x, input logic [7:0] c);
    bit took;
    took = 1'b0;
    case (x.ps)
      PS_BEGIN: begin
        if (c == CH_Q) begin
          x.star_type = STAR_NEUTRON;
          x.ps = PS_END;
        end else if (c == CH_X) begin
          x.star_type = STAR_BH;
          x.ps = PS_END;
        end else if (c == CH_D) begin
          x.star_type = STAR_WD;
          x.spec_class = CLS_D;
          x.ps = PS_WD_TYPE;
          took = 1'b1;
        end else if (c == "s") begin
          x.ps = PS_SUBDWARF;
          took = 1'b1;
        end else if (c == "?") begin
          x.ps = PS_END;
        end else begin
          x.ps = PS_CLASS;
        end
      end
      PS_WR_TYPE: begin
        x.ps = PS_SUB;
        if (c == "N") begin
          x.spec_class = CLS_WN;
          took = 1'b1;
        end else begin
          x.spec_class = CLS_WC;
          took = (c == "C");
        end
      end
      PS_SUBDWARF: begin
        if (c == "d") begin
          x.lum = LUM_VI;
          x.ps = PS_CLASS;
          took = 1'b1;
        end else begin
          x.ps = PS_END;
        end
      end
      PS_CLASS: begin
        took = 1'b1;
        x.ps = PS_SUB;
        case (c)
          CH_W: x.ps = PS_WR_TYPE;
          "O": x.spec_class = CLS_O;
          "B": x.spec_class = CLS_B;
          "A": x.spec_class = CLS_A;
          "F": x.spec_class = CLS_F;
          "G": x.spec_class = CLS_G;
          "K": x.spec_class = CLS_K;
          "M": x.spec_class = CLS_M;
          "R": x.spec_class = CLS_R;
          "S": x.spec_class = CLS_S;
          "N": x.spec_class = CLS_N;
          "L": x.spec_class = CLS_L;
          "T": x.spec_class = CLS_T;
          "C": x.spec_class = CLS_C;
          default: x.ps = PS_END;
        endcase
      end
      PS_SUB: begin
        if (is_numeral(c)) begin
          x.subclass = c[3:0];
          x.ps = PS_SUB_DEC;
          took = 1'b1;
        end else begin
          x.ps = PS_LUM_BEGIN;
        end
      end
      PS_SUB_DEC: begin
        if (c == CH_DOT) begin
          x.ps = PS_SUB_FIN;
          took = 1'b1;
        end else begin
          x.ps = PS_LUM_BEGIN;
        end
      end
      PS_SUB_FIN: begin
        x.ps = is_numeral(c) ? PS_LUM_BEGIN : PS_END;
        took = 1'b1;
      end
      PS_LUM_BEGIN: begin
        took = 1'b1;
        if (c == "I") x.ps = PS_LUM_I;
        else if (c == "V") x.ps = PS_LUM_V;
        else x.ps = PS_END;
      end
      PS_LUM_I: begin
        took = 1'b1;
        if (c == "I") begin
          x.ps = PS_LUM_II;
        end else if (c == "V") begin
          x.lum = LUM_IV;
          x.ps = PS_END;
        end else if (c == "a") begin
          x.ps = PS_LUM_IA;
        end else if (c == CH_DASH) begin
          x.ps = PS_LUM_IDASH;
        end else begin
          x.lum = LUM_IB;
          x.ps = PS_END;
        end
      end
      PS_LUM_II: begin
        if (c == "I") x.lum = LUM_III;
        else x.lum = LUM_II;
        x.ps = PS_END;
      end
      PS_LUM_IDASH: begin
        // The 'a' after the dash is left for the Ia state to read again.
        if (c == "a") begin
          x.ps = PS_LUM_IA;
        end else begin
          x.lum = LUM_IB;
          x.ps = PS_END;
        end
      end
      PS_LUM_IA: begin
        if (c == "0") x.lum = LUM_IA0;
        else x.lum = LUM_IA;
        x.ps = PS_END;
      end
      PS_LUM_V: begin
        if (c == "I") x.lum = LUM_VI;
        else x.lum = LUM_V;
        x.ps = PS_END;
      end
      PS_WD_TYPE: begin
        x.ps = PS_WD_EXT;
        took = 1'b1;
        case (c)
          "A": x.spec_class = CLS_DA;
          "B": x.spec_class = CLS_DB;
          "C": x.spec_class = CLS_DC;
          "O": x.spec_class = CLS_DO;
          "Q": x.spec_class = CLS_DQ;
          "Z": x.spec_class = CLS_DZ;
          default: begin
            x.spec_class = CLS_D;
            took = 1'b0;
          end
        endcase
      end
      PS_WD_EXT: begin
        case (c)
          "A", "B", "C", "O", "Q", "Z", "V", "P", "H", "E": took = 1'b1;
          default: x.ps = PS_WD_SUB;
        endcase
      end
      PS_WD_SUB: begin
        x.ps = PS_END;
        if (is_numeral(c)) begin
          x.subclass = c[3:0];
          took = 1'b1;
        end
      end
      default: x.ps = PS_END;
    endcase
    return took;
  endfunction

  // Predict on each input transfer and compare on each output transfer.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    bit       used;
    if (rst) begin
      scan = CtxReset;
      expected_readings.delete();
      misses = 0;
    end else begin
      if (in_valid && in_ready) begin
        used = 1'b0;
        for (int n = 0; n < ChainCap && scan.ps != PS_END && !used; n++) begin
          used = advance(scan, ch);
          // The terminator runs every remaining transition.
          if (ch == CH_NUL) used = 1'b0;
        end
        if (ch == CH_NUL) begin
          expected_readings.push_back('{scan.star_type, scan.spec_class, scan.subclass,
                                        scan.lum});
          scan = CtxReset;
        end
      end
      if (out_valid && out_ready) begin
        got = '{star_type_t'(star_type), spec_class_t'(spectral_class), subclass_digit,
                lum_class_t'(lum_class)};
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, got %0d %0d %0d %0d", $time,
                   star_type, spectral_class, subclass_digit, lum_class);
          misses++;
        end else begin
          want = expected_readings.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: star_type expected %0d got %0d", $time, want.kind, star_type);
            misses++;
          end
          if (got.cls !== want.cls) begin
            $display("%0t: spectral_class expected %0d got %0d", $time, want.cls,
                     spectral_class);
            misses++;
          end
          if (got.sub !== want.sub) begin
            $display("%0t: subclass_digit expected %0d got %0d", $time, want.sub,
                     subclass_digit);
            misses++;
          end
          if (got.lum !== want.lum) begin
            $display("%0t: lum_class expected %0d got %0d", $time, want.lum, lum_class);
            misses++;
          end
        end
      end
    end
    open_readings = expected_readings.size();
  end

endmodule

@@ verif/stellar_spectral_type_parser_test.sv @@
// Top of the spectral type parser testbench: clock, reset, character stimulus,
// output back-pressure and the verdict. Depends on sstp_pkg, the parser and
// spectral_reading_checker.
module stellar_spectral_type_parser_test;
  import sstp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TextItems  = 1650;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] ch;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] star_type;
  logic [4:0] spectral_class;
  logic [3:0] subclass_digit;
  logic [3:0] lum_class;

  int misses;
  int open_readings;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_chars = 0;
  int cycle_count = 0;

  logic [7:0] text[$];
  string lum_forms[16] = '{"I", "II", "III", "IV", "V", "VI", "Ia", "Ia0", "Ib", "I-a",
                           "I-a0", "I-b", "Iab", "VII", "Iz", ""};

  stellar_spectral_type_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
    .out_valid(out_valid), .out_ready(out_ready),
    .star_type(star_type), .spectral_class(spectral_class),
    .subclass_digit(subclass_digit), .lum_class(lum_class)
  );

  spectral_reading_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
    .out_valid(out_valid), .out_ready(out_ready),
    .star_type(star_type), .spectral_class(spectral_class),
    .subclass_digit(subclass_digit), .lum_class(lum_class),
    .misses(misses), .open_readings(open_readings)
  );

  always #1 clk = ~clk;

  // Give up if the run takes far longer than the slowest correct one.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("stellar_spectral_type_parser test failed");
      $finish;
    end
  end

  // The receiver stalls at random on the current idle rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add(input string s);
    foreach (s[i]) text.push_back(s[i]);
  endtask

  // Drive one character and hold it until its transfer.
  task automatic put_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the collected text followed by its terminator.
  task automatic send_text();
    foreach (text[i]) put_char(text[i]);
    put_char(CH_NUL);
    sent_chars += text.size() + 1;
    text.delete();
  endtask

  // Mostly well-formed spectral types with random content, some noise and damage.
  task automatic compose_text();
    int form;
    int kind;
    form = $urandom_range(0, 99);
    if (form < 12) begin
      repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: text.push_back(pick("QX?"));
        1: begin
          text.push_back(CH_D);
          if ($urandom_range(0, 9) < 7) text.push_back(pick("ABCOQZ"));
          repeat ($urandom_range(0, 2)) text.push_back(pick("ABCOQZVPHE"));
          if ($urandom_range(0, 9) < 7) text.push_back(pick("0123456789"));
        end
        2: begin
          add("s");
          if ($urandom_range(0, 9) < 8) add("d");
          text.push_back(pick("OBAFGKMRSNLTCWx"));
        end
        3: begin
          text.push_back(CH_W);
          text.push_back(pick("NCX"));
        end
        default: text.push_back(pick("OBAFGKMRSNLTC"));
      endcase
      // Subclass and luminosity follow the class letter.
      if (kind >= 2) begin
        if ($urandom_range(0, 9) < 8) text.push_back(pick("0123456789"));
        if ($urandom_range(0, 9) < 2) begin
          text.push_back(CH_DOT);
          text.push_back(pick("0123456789x"));
        end
        add(lum_forms[$urandom_range(0, 15)]);
      end
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
      end
      if (text.size() > 0 && $urandom_range(0, 9) == 0) begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    ch = CH_NUL;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 59;

    // Directed strings: empty string, the I-a case, ignored tail after the end
    // state, digit edges with a decimal, top-bit bytes and a white dwarf.
    send_text();
    add("B2I-a0");
    send_text();
    add("Qz");
    text.push_back(8'hFF);
    send_text();
    add("K9.0III");
    send_text();
    text.push_back(8'h80);
    send_text();
    add("DA3");
    send_text();

    while (sent_chars < TextItems) begin
      if (sent_chars >= 2 * TextItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent_chars >= TextItems / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 9;
      end
      compose_text();
      send_text();
    end
    in_valid <= 1'b0;

    while (open_readings != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (misses == 0 && open_readings == 0) begin
      $display("stellar_spectral_type_parser test passed");
    end else begin
      $display("stellar_spectral_type_parser test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sstp_pkg.sv
rtl/sstp_step.sv
rtl/sstp_core.sv
rtl/stellar_spectral_type_parser.sv
verif/spectral_reading_checker.sv
verif/stellar_spectral_type_parser_test.sv
